>>> hdl/tlpt_pkg.sv
package tlpt_pkg;

  localparam int TABLE_SLOTS       = 4;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int SLOT_W            = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PAGE_W            = $clog2(ENTRIES_PER_TABLE);
  localparam int ENTRY_AW          = SLOT_W + PAGE_W;
  localparam int ENTRY_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int DIR_LSB           = 22;
  localparam int DIR_W             = 32 - DIR_LSB;
  localparam int OFFSET_W          = 12;
  localparam int LIMIT_W           = 3;
  localparam int APB_AW            = 3;
  localparam int APB_DW            = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(4);
  localparam logic [APB_AW-1:0]  ADDR_TABLE_LIM = APB_AW'(0);

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_MAP       = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_NO_TABLE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [31:0]         virtual_address;
    logic [31:0]         map_address;
    logic [OFFSET_W-1:0] entry_flags;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         translated_address;
    logic [OFFSET_W-1:0] page_flags;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/tlpt_ram.sv
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tlpt_ctrl.sv
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/tlpt_dpath.sv
module tlpt_dpath
  import tlpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_word_t          in_word_i,
  output out_word_t         out_word_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o
);

  logic [ENTRY_AW-1:0]    clr_cnt_q;
  in_word_t               item_q;
  logic [TABLE_SLOTS-1:0] dir_present_q, dir_present_d;
  logic [LIMIT_W-1:0]     limit_q;
  out_word_t              out_q, out_d;
  logic                   out_valid_q;

  logic [31:0]         rdata;
  logic [31:0]         wdata;
  logic [ENTRY_AW-1:0] waddr;
  logic [ENTRY_AW-1:0] raddr;
  logic [ENTRY_AW-1:0] item_addr;
  logic                upd_we;
  logic                we;
  logic [DIR_W-1:0]    dir;
  logic                dir_in_range;
  logic                dir_ok;
  logic                dir_can_install;
  logic                ent_present;

  assign raddr = {in_word_i.virtual_address[DIR_LSB +: SLOT_W],
                  in_word_i.virtual_address[OFFSET_W +: PAGE_W]};
  assign item_addr = {item_q.virtual_address[DIR_LSB +: SLOT_W],
                      item_q.virtual_address[OFFSET_W +: PAGE_W]};

  assign dir          = item_q.virtual_address[31:DIR_LSB];
  assign dir_in_range = ({1'b0, dir} < (DIR_W + 1)'(TABLE_SLOTS));
  assign dir_ok       = dir_in_range && dir_present_q[dir[SLOT_W-1:0]];
  assign dir_can_install = dir_in_range && (dir < DIR_W'(limit_q));
  assign ent_present  = dir_ok && rdata[0];

  always_comb begin
    out_d         = '0;
    upd_we        = 1'b0;
    wdata         = '0;
    dir_present_d = dir_present_q;
    unique case (item_q.operation)
      OP_TRANSLATE: begin
        if (ent_present) begin
          out_d.status             = ST_OK;
          out_d.translated_address = {rdata[31:OFFSET_W],
                                      item_q.virtual_address[OFFSET_W-1:0]};
          out_d.page_flags         = rdata[OFFSET_W-1:0];
        end else begin
          out_d.status = ST_NOT_PRESENT;
        end
      end
      OP_MAP: begin
        if (dir_ok || dir_can_install) begin
          out_d.status = ST_OK;
          upd_we       = 1'b1;
          wdata        = {item_q.map_address[31:OFFSET_W],
                          item_q.entry_flags | OFFSET_W'(1)};
          dir_present_d[dir[SLOT_W-1:0]] = 1'b1;
        end else begin
          out_d.status = ST_NO_TABLE;
        end
      end
      OP_UNMAP: begin
        if (ent_present) begin
          out_d.status = ST_OK;
          upd_we       = 1'b1;
          wdata        = {rdata[31:1], 1'b0};
        end else begin
          out_d.status = ST_NOT_PRESENT;
        end
      end
      default: begin
        out_d.status = ST_OK;
      end
    endcase
  end

  assign we    = cmd_i.clear || (cmd_i.finish && upd_we);
  assign waddr = cmd_i.clear ? clr_cnt_q : item_addr;

  tlpt_ram #(
    .WIDTH(32),
    .DEPTH(ENTRY_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.clear ? 32'd0 : wdata),
    .re_i   (cmd_i.capture),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q     <= '0;
      dir_present_q <= '0;
      limit_q       <= LIMIT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + ENTRY_AW'(1);
      end
      if (cmd_i.finish) begin
        dir_present_q <= dir_present_d;
      end
      if (psel && penable && pwrite && (paddr == ADDR_TABLE_LIM)) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_word_i;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign prdata = (paddr == ADDR_TABLE_LIM) ? APB_DW'(limit_q) : '0;

  assign sts_o.clear_last = (clr_cnt_q == ENTRY_AW'(ENTRY_DEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/two_level_page_table_engine.sv
// channel   direction  handshake                 word
// in        input      in_valid_i / in_stall_o   in_word_i   (in_word_t)
// out       output     out_valid_o / out_stall_i out_word_o  (out_word_t)
// cfg       input      APB psel/penable/pwrite   table_limit at address 0
//
// Each word goes through one entry RAM read, then decide and write back.
// The entry RAM read is registered; one word is in flight.
// After reset all 4096 entry RAM words are cleared, with in_stall_o high.
// A result waits in the output register while out_stall_i is high.
module two_level_page_table_engine
  import tlpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign pready = 1'b1;

  tlpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tlpt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous word still in lookup");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != ST_OK)) |->
      ((out_word_o.translated_address == '0) && (out_word_o.page_flags == '0)))
    else $error("failed result carries nonzero address or flags");

  a_result_after_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a lookup cycle");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status != 2'd3))
    else $error("undefined status code");

endmodule
